// ----- sv/cfade_pkg.sv -----
// Shared types and constants for the color fade and gradient blender.
// Used by every module of the block; depends on nothing.
package cfade_pkg;

    // Widths and defaults.
    localparam int POSITION_BITS_DEF = 12;
    localparam int COLOR_W           = 24;
    localparam int CHAN_W            = 8;
    localparam int NUM_CHAN          = 3;
    localparam int PCT_W             = 7;
    localparam int QUOT_BITS         = 7;
    localparam int CFG_INDEX_W       = 2;

    // Full blend amount in percent.
    localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

    // Division by one hundred as a reciprocal multiply: exact for magnitudes up to 25500.
    localparam int               DIV100_MULT_W = 13;
    localparam logic [DIV100_MULT_W-1:0] DIV100_MULT = 13'd5243;
    localparam int               DIV100_SHIFT  = 19;

    // Front stage, one stage per quotient bit, three blend stages.
    localparam int PIPE_DEPTH = 1 + QUOT_BITS + 3;

    // Reset values of the configuration registers.
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 24'hFFFFFF;
    localparam logic [31:0]        LENGTH_RESET = 32'd256;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_COLOR = 2'd0,
        REG_FADE_PERCENT = 2'd1,
        REG_GRAD_START   = 2'd2,
        REG_GRAD_LENGTH  = 2'd3
    } cfg_reg_t;

    // Operation selector carried on tuser.
    typedef enum logic {
        OP_FADE     = 1'b0,
        OP_GRADIENT = 1'b1
    } op_t;

    // Colour registers and fade amount, shared from the register file.
    typedef struct packed {
        logic [COLOR_W-1:0] target_color;
        logic [COLOR_W-1:0] start_color;
        logic [PCT_W-1:0]   fade_percent;
    } cfg_t;

    // Information that travels beside the divider.
    typedef struct packed {
        logic [COLOR_W-1:0] src;
        logic [PCT_W-1:0]   pct;
        logic               use_div;
    } side_t;

endpackage

// ----- sv/cfade_regs.sv -----
// Configuration register file of the color fade and gradient blender.
// Depends on cfade_pkg.
module cfade_regs #(
    parameter int POSITION_BITS = cfade_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cfade_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cfade_pkg::COLOR_W-1:0]       cfg_data,
    output cfade_pkg::cfg_t                     cfg,
    output logic [POSITION_BITS-1:0]            grad_length
);

    logic [cfade_pkg::COLOR_W-1:0] target_reg;
    logic [cfade_pkg::COLOR_W-1:0] start_reg;
    logic [cfade_pkg::PCT_W-1:0]   fade_reg;
    logic [POSITION_BITS-1:0]      length_reg;

    // Register writes; an index without a register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= cfade_pkg::COLOR_RESET;
            fade_reg   <= '0;
            start_reg  <= cfade_pkg::COLOR_RESET;
            length_reg <= cfade_pkg::LENGTH_RESET[POSITION_BITS-1:0];
        end
        else if (cfg_we)
        begin
            case (cfade_pkg::cfg_reg_t'(cfg_index))
                cfade_pkg::REG_TARGET_COLOR: target_reg <= cfg_data;
                cfade_pkg::REG_FADE_PERCENT: fade_reg   <= cfg_data[cfade_pkg::PCT_W-1:0];
                cfade_pkg::REG_GRAD_START:   start_reg  <= cfg_data;
                cfade_pkg::REG_GRAD_LENGTH:  length_reg <= cfg_data[POSITION_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.target_color = target_reg;
    assign cfg.start_color  = start_reg;
    assign cfg.fade_percent = fade_reg;
    assign grad_length      = length_reg;

endmodule

// ----- sv/cfade_div.sv -----
// Pipelined restoring divider that turns position times one hundred into a percent.
// One quotient bit per stage; depends on cfade_pkg.
module cfade_div #(
    parameter int POSITION_BITS = cfade_pkg::POSITION_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [POSITION_BITS+cfade_pkg::QUOT_BITS-1:0]   in_num,
    input  cfade_pkg::side_t                                in_side,
    input  logic [POSITION_BITS-1:0]                        den,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [cfade_pkg::QUOT_BITS-1:0]                 out_quot,
    output cfade_pkg::side_t                                out_side
);

    localparam int QB    = cfade_pkg::QUOT_BITS;
    localparam int NUM_W = POSITION_BITS + QB;

    logic [QB-1:0]      v_reg;
    logic [QB-1:0]      en;
    logic [QB-1:0]      v_in;
    logic [NUM_W-1:0]   rem_in    [QB];
    logic [QB-1:0]      quot_in   [QB];
    cfade_pkg::side_t   side_in   [QB];
    logic [NUM_W-1:0]   rem_next  [QB];
    logic [QB-1:0]      quot_next [QB];
    logic [NUM_W-1:0]   rem_reg   [QB];
    logic [QB-1:0]      quot_reg  [QB];
    cfade_pkg::side_t   side_reg  [QB];

    // A stage moves when it is empty or the one after it moves.
    always_comb
    begin
        en[QB-1] = !v_reg[QB-1] || out_ready;
        for (int k = QB - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    // Stage inputs come from the port or from the previous stage.
    always_comb
    begin
        v_in[0]    = in_valid;
        rem_in[0]  = in_num;
        quot_in[0] = '0;
        side_in[0] = in_side;
        for (int k = 1; k < QB; k++)
        begin
            v_in[k]    = v_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            quot_in[k] = quot_reg[k-1];
            side_in[k] = side_reg[k-1];
        end
    end

    // Trial subtraction of the divisor shifted to each stage's quotient bit.
    always_comb
    begin
        logic [NUM_W-1:0] trial;
        logic             fits;
        for (int k = 0; k < QB; k++)
        begin
            trial        = {{QB{1'b0}}, den} << (QB - 1 - k);
            fits         = (rem_in[k] >= trial);
            rem_next[k]  = fits ? (rem_in[k] - trial) : rem_in[k];
            quot_next[k] = quot_in[k];
            quot_next[k][QB-1-k] = fits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < QB; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QB; k++)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[QB-1];
    assign out_quot  = quot_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

// ----- sv/cfade_blend.sv -----
// Three-stage channel blender: scale the difference, divide by one hundred, subtract.
// Depends on cfade_pkg.
module cfade_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cfade_pkg::QUOT_BITS-1:0]     in_quot,
    input  cfade_pkg::side_t                    in_side,
    input  logic [cfade_pkg::COLOR_W-1:0]       target,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cfade_pkg::COLOR_W-1:0]       out_color
);

    localparam int NC     = cfade_pkg::NUM_CHAN;
    localparam int CW     = cfade_pkg::CHAN_W;
    localparam int PROD_W = 16;
    localparam int MAG_W  = PROD_W - 1;
    localparam int SCL_W  = MAG_W + cfade_pkg::DIV100_MULT_W;

    logic [2:0] v_reg;
    logic [2:0] en;

    // Stage handshakes: a stage moves when it is empty or the next one moves.
    assign en[2]     = !v_reg[2] || out_ready;
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // First stage: signed channel difference times the percent.
    logic [cfade_pkg::PCT_W-1:0]       pct;
    logic signed [PROD_W-1:0]          prod_next [NC];
    logic signed [PROD_W-1:0]          prod_reg  [NC];
    logic [cfade_pkg::COLOR_W-1:0]     src0_reg;

    always_comb
    begin
        logic signed [PROD_W-1:0] diff;
        logic signed [PROD_W-1:0] pct_s;
        pct   = in_side.use_div ? in_quot : in_side.pct;
        pct_s = {{(PROD_W-cfade_pkg::PCT_W){1'b0}}, pct};
        for (int c = 0; c < NC; c++)
        begin
            diff = $signed({{(PROD_W-CW){1'b0}}, in_side.src[c*CW +: CW]})
                 - $signed({{(PROD_W-CW){1'b0}}, target[c*CW +: CW]});
            prod_next[c] = diff * pct_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
            src0_reg <= in_side.src;
        end
    end

    // Second stage: magnitude times the reciprocal of one hundred.
    logic [SCL_W-1:0]               scaled_next [NC];
    logic [SCL_W-1:0]               scaled_reg  [NC];
    logic [NC-1:0]                  neg_reg;
    logic [cfade_pkg::COLOR_W-1:0]  src1_reg;

    always_comb
    begin
        logic [PROD_W-1:0] mag;
        for (int c = 0; c < NC; c++)
        begin
            mag = prod_reg[c][PROD_W-1] ? (-prod_reg[c]) : prod_reg[c];
            scaled_next[c] = SCL_W'(mag[MAG_W-1:0]) * SCL_W'(cfade_pkg::DIV100_MULT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            scaled_reg <= scaled_next;
            for (int c = 0; c < NC; c++)
            begin
                neg_reg[c] <= prod_reg[c][PROD_W-1];
            end
            src1_reg <= src0_reg;
        end
    end

    // Third stage: take the truncated step off the source channel.
    logic [cfade_pkg::COLOR_W-1:0] color_next;
    logic [cfade_pkg::COLOR_W-1:0] color_reg;

    always_comb
    begin
        logic [CW-1:0] step;
        for (int c = 0; c < NC; c++)
        begin
            step = scaled_reg[c][cfade_pkg::DIV100_SHIFT +: CW];
            color_next[c*CW +: CW] = neg_reg[c] ? (src1_reg[c*CW +: CW] + step)
                                                : (src1_reg[c*CW +: CW] - step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            color_reg <= color_next;
        end
    end

    assign out_color = color_reg;

endmodule

// ----- sv/color_fade_gradient.sv -----
// Color fade and gradient blender, one result per request.
// Pipeline: front stage, 7 divider stages for the gradient percent, 3 blend stages;
// throughput one request per cycle while the output is not stalled.
// A stalled output holds only the stages behind it; empty stages still fill.
// Asynchronous active-low reset empties the pipeline and loads the register defaults.
// Depends on cfade_pkg, cfade_regs, cfade_div and cfade_blend.
module color_fade_gradient #(
    parameter  int POSITION_BITS = cfade_pkg::POSITION_BITS_DEF,
    localparam int IN_DATA_W     = ((cfade_pkg::COLOR_W + POSITION_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cfade_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cfade_pkg::COLOR_W-1:0]       cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pixel_color [23:0], position [23+POSITION_BITS:24], zero fill above
    input  logic [IN_DATA_W-1:0]                s_axis_tdata,
    // operation [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_color [23:0]
    output logic [cfade_pkg::COLOR_W-1:0]       m_axis_tdata
);

    localparam int QB    = cfade_pkg::QUOT_BITS;
    localparam int NUM_W = POSITION_BITS + QB;

    cfade_pkg::cfg_t           cfg;
    logic [POSITION_BITS-1:0]  grad_length;

    cfade_regs #(
        .POSITION_BITS (POSITION_BITS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .grad_length (grad_length)
    );

    // Front stage: clamp the position, scale it by one hundred, pick source and percent.
    logic                          div_in_ready;
    logic                          front_en;
    logic                          f_valid_reg;
    logic [NUM_W-1:0]              f_num_reg;
    cfade_pkg::side_t              f_side_reg;
    logic [NUM_W-1:0]              num_next;
    cfade_pkg::side_t              side_next;

    always_comb
    begin
        logic [POSITION_BITS-1:0] pos;
        logic [POSITION_BITS-1:0] pos_c;
        pos      = s_axis_tdata[cfade_pkg::COLOR_W +: POSITION_BITS];
        pos_c    = (pos > grad_length) ? grad_length : pos;
        num_next = NUM_W'(pos_c) * NUM_W'(cfade_pkg::FULL_PCT);
        if (cfade_pkg::op_t'(s_axis_tuser) == cfade_pkg::OP_GRADIENT)
        begin
            side_next.src     = cfg.start_color;
            side_next.pct     = cfade_pkg::FULL_PCT;
            side_next.use_div = (grad_length != '0);
        end
        else
        begin
            side_next.src     = s_axis_tdata[cfade_pkg::COLOR_W-1:0];
            side_next.pct     = (cfg.fade_percent > cfade_pkg::FULL_PCT) ?
                                cfade_pkg::FULL_PCT : cfg.fade_percent;
            side_next.use_div = 1'b0;
        end
    end

    assign front_en      = !f_valid_reg || div_in_ready;
    assign s_axis_tready = front_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            f_num_reg  <= num_next;
            f_side_reg <= side_next;
        end
    end

    // Gradient percent divider.
    logic              div_out_valid;
    logic              blend_in_ready;
    logic [QB-1:0]     div_quot;
    cfade_pkg::side_t  div_side;

    cfade_div #(
        .POSITION_BITS (POSITION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .in_ready  (div_in_ready),
        .in_num    (f_num_reg),
        .in_side   (f_side_reg),
        .den       (grad_length),
        .out_valid (div_out_valid),
        .out_ready (blend_in_ready),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Channel blend and output register.
    cfade_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_out_valid),
        .in_ready  (blend_in_ready),
        .in_quot   (div_quot),
        .in_side   (div_side),
        .target    (cfg.target_color),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_color (m_axis_tdata)
    );

endmodule

// ----- sv/cfade_checker.sv -----
// Port-level checker for color_fade_gradient, attached with a bind statement.
// Depends on cfade_pkg.
module cfade_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [cfade_pkg::COLOR_W-1:0]   m_axis_tdata
);

    localparam int CNT_W = $clog2(cfade_pkg::PIPE_DEPTH + 2);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             in_acc;
    logic             out_acc;

    // Requests accepted but not yet delivered.
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result is shown only for a request that is still in flight.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (inflight_reg != '0))
        else $error("result shown with no request in flight");

    // The pipeline never holds more than its depth.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(cfade_pkg::PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // Input back-pressure only comes from a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output is free");

    // A stalled result stays valid and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind color_fade_gradient cfade_checker u_cfade_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
